@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ sv/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// sme_pkg
// Types and codes shared by the stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;

  typedef struct packed {
    logic [15:0] func;
    logic [15:0] operand;
    logic signed [31:0] read_value;
  } sme_in_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [2:0]  event_res;
    logic signed [31:0] event_value;
    logic [2:0]  error_code;
  } sme_out_t;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_PRINT = 3'd1;
  localparam logic [2:0] EV_STR   = 3'd2;
  localparam logic [2:0] EV_HALT  = 3'd3;
  localparam logic [2:0] EV_ERR   = 3'd4;

  localparam logic [2:0] ER_NONE  = 3'd0;
  localparam logic [2:0] ER_OVF   = 3'd1;
  localparam logic [2:0] ER_UNF   = 3'd2;
  localparam logic [2:0] ER_DIV0  = 3'd3;
  localparam logic [2:0] ER_OPC   = 3'd4;

  localparam logic [15:0] OP_HALT = 16'd0,  OP_PUSH = 16'd1,  OP_RVAL = 16'd2,
    OP_LVAL = 16'd3,  OP_POP = 16'd4,  OP_STO = 16'd5,  OP_COPY = 16'd6,
    OP_ADD = 16'd7,  OP_SUB = 16'd8,  OP_MPY = 16'd9,  OP_DIV = 16'd10,
    OP_MOD = 16'd11, OP_NEG = 16'd12, OP_NOT = 16'd13, OP_AND = 16'd14,
    OP_OR = 16'd15,  OP_EQ = 16'd16,  OP_NE = 16'd17,  OP_GT = 16'd18,
    OP_GE = 16'd19,  OP_LT = 16'd20,  OP_LE = 16'd21,  OP_LABEL = 16'd22,
    OP_GOTO = 16'd23, OP_GOF = 16'd24, OP_GOT = 16'd25, OP_PRINT = 16'd26,
    OP_READ = 16'd27, OP_GOSUB = 16'd28, OP_RET = 16'd29, OP_PUTS = 16'd30,
    OP_DREF = 16'd31;

endpackage

@@ sv/stack_machine_executor.sv @@
// ----------------------------------------------------------------------------
// stack_machine_executor
// Executes one stack-machine instruction per item on a data memory with stack.
// ----------------------------------------------------------------------------
// Sequence: states read top, read second, indirect read, execute, write back and
// output; DIV and MOD with a nonzero divisor and an operand to pop add a
// 32-step restoring divider before write back; an item while stopped is answered from idle.
// Throughput: one item in flight; the next is accepted only after the output state.
// Reset: pc, stack pointer and stop state reset at once; a clearing pass over
// all DATA_DEPTH words then zeroes the data memory while no item is accepted.
module stack_machine_executor
  import sme_pkg::*;
#(
  parameter int DATA_DEPTH = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sme_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sme_out_t out_data
);

  localparam int AW = $clog2(DATA_DEPTH);
  localparam int SW = AW + 1;
  localparam logic [SW-1:0] SP_RST  = SW'(DATA_DEPTH - 1);
  localparam logic [SW-1:0] SP_HALF = SW'(DATA_DEPTH / 2);
  localparam logic [SW-1:0] SP_FULL = SW'(DATA_DEPTH);

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_RDA  = 9'b000000100,
    S_RDB  = 9'b000001000,
    S_RDC  = 9'b000010000,
    S_EXE  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_WB   = 9'b010000000,
    S_OUT  = 9'b100000000
  } st_t;

  st_t st_r;
  logic [AW-1:0] clr_r;
  logic [15:0] pc_r;
  logic [SW-1:0] sp_r;
  logic stop_r;
  logic [2:0] scode_r;
  sme_in_t in_r;
  logic [31:0] ta_r, tb_r, tc_r;   // top, second, indirect read data or MPY/DIV/MOD result
  sme_out_t out_r;
  logic ov_r;

  // data memory, one port, registered read
  logic [31:0] mem [DATA_DEPTH];
  logic [31:0] rdata_r;
  logic        we;
  logic [AW-1:0] maddr;
  logic [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[maddr] <= wdata;
    rdata_r <= mem[maddr];
  end

  // divider
  logic [31:0] dq_r, drem_r, dmb_r;
  logic [5:0]  dcnt_r;
  logic        dna_r, dnb_r;
  logic [32:0] dtrial;
  assign dtrial = {drem_r, dq_r[31]} - {1'b0, dmb_r};

  logic [31:0] sx;
  assign sx = {{16{in_r.operand[15]}}, in_r.operand};
  logic [15:0] npc1;
  assign npc1 = pc_r + 16'd1;

  logic [31:0] a, b;
  assign b = ta_r;
  assign a = tb_r;
  logic sgt_ab, sgt_ba;
  assign sgt_ab = $signed(a) > $signed(b);
  assign sgt_ba = $signed(b) > $signed(a);

  // execute decode
  logic [2:0]  fault;
  logic        halt, do_wr;
  logic [AW-1:0] waddr;
  logic [31:0] wval;
  logic [SW-1:0] sp_n;
  logic [15:0] npc;
  logic [2:0]  ev;
  logic [31:0] val;
  logic        can_push, can_pop;
  logic [SW-1:0] spm1, spp1;
  assign can_push = sp_r >= SP_HALF;
  assign can_pop  = sp_r < SP_FULL;
  assign spm1 = sp_r - SW'(1);
  assign spp1 = sp_r + SW'(1);

  always_comb begin
    fault = ER_NONE; halt = 1'b0; do_wr = 1'b0; waddr = spm1[AW-1:0];
    wval = 32'd0; sp_n = sp_r; npc = npc1; ev = EV_NONE; val = 32'd0;
    case (in_r.func)
      OP_HALT: halt = 1'b1;
      OP_PUSH, OP_LVAL, OP_RVAL, OP_COPY, OP_READ, OP_GOSUB: begin
        if (!can_push) fault = ER_OVF;
        else begin
          do_wr = 1'b1; sp_n = spm1;
          case (in_r.func)
            OP_RVAL:  wval = tc_r;
            OP_COPY:  wval = b;
            OP_READ:  wval = in_r.read_value;
            OP_GOSUB: wval = {16'd0, npc1};
            default:  wval = sx;
          endcase
          if (in_r.func == OP_GOSUB) npc = in_r.operand;
        end
      end
      OP_POP: if (!can_pop) fault = ER_UNF; else sp_n = spp1;
      OP_STO: begin
        if (!can_pop) fault = ER_UNF;
        else begin
          do_wr = 1'b1; waddr = a[AW-1:0]; wval = b;
          if (spp1 >= SP_FULL) fault = ER_UNF; else sp_n = sp_r + SW'(2);
        end
      end
      OP_NEG: begin
        if (!can_pop) fault = ER_UNF;
        else if (spp1 < SP_HALF) fault = ER_OVF;
        else begin do_wr = 1'b1; waddr = sp_r[AW-1:0]; wval = 32'd0 - b; end
      end
      OP_NOT: begin do_wr = 1'b1; waddr = sp_r[AW-1:0]; wval = ~b; end
      OP_ADD, OP_SUB, OP_MPY, OP_AND, OP_OR, OP_EQ, OP_NE, OP_GT, OP_GE,
      OP_LT, OP_LE, OP_DIV, OP_MOD: begin
        if ((in_r.func inside {OP_DIV, OP_MOD}) && b == 32'd0)
          fault = ER_DIV0;
        else if (!can_pop) fault = ER_UNF;
        else begin
          do_wr = 1'b1; waddr = spp1[AW-1:0]; sp_n = spp1;
          case (in_r.func)
            OP_ADD: wval = a + b;
            OP_SUB: wval = a - b;
            OP_MPY: wval = tc_r;
            OP_AND: wval = a & b;
            OP_OR:  wval = a | b;
            OP_EQ:  wval = {31'd0, a == b};
            OP_NE:  wval = {31'd0, a != b};
            OP_GT:  wval = {31'd0, sgt_ab};
            OP_GE:  wval = {31'd0, !sgt_ba};
            OP_LT:  wval = {31'd0, sgt_ba};
            OP_LE:  wval = {31'd0, !sgt_ab};
            default: wval = tc_r;
          endcase
        end
      end
      OP_LABEL: ;
      OP_GOTO: npc = in_r.operand;
      OP_GOF, OP_GOT, OP_PRINT, OP_PUTS, OP_RET: begin
        if (!can_pop) fault = ER_UNF;
        else begin
          sp_n = spp1;
          case (in_r.func)
            OP_GOF: if (b == 32'd0) npc = in_r.operand;
            OP_GOT: if (b != 32'd0) npc = in_r.operand;
            OP_PRINT: begin ev = EV_PRINT; val = b; end
            OP_PUTS: begin ev = EV_STR; val = b; end
            default: npc = b[15:0];
          endcase
        end
      end
      OP_DREF: begin
        if (!can_pop) fault = ER_UNF;
        else if (spp1 < SP_HALF) fault = ER_OVF;
        else begin do_wr = 1'b1; waddr = sp_r[AW-1:0]; wval = tc_r; end
      end
      default: fault = ER_OPC;
    endcase
  end

  logic is_div;
  assign is_div = in_r.func inside {OP_DIV, OP_MOD};
  logic need_c;
  assign need_c = in_r.func inside {OP_RVAL, OP_DREF};

  // write back only when the instruction completes without a fault
  logic wb_fire;
  assign wb_fire = do_wr && fault == ER_NONE;

  // memory address / write select
  always_comb begin
    we = 1'b0; maddr = sp_r[AW-1:0]; wdata = wval;
    case (st_r)
      S_CLR: begin we = 1'b1; maddr = clr_r; wdata = 32'd0; end
      S_RDB: maddr = spp1[AW-1:0];
      S_RDC: maddr = (in_r.func == OP_DREF) ? ta_r[AW-1:0] : sx[AW-1:0];
      S_WB:  begin we = wb_fire; maddr = waddr; end
      default: maddr = sp_r[AW-1:0];
    endcase
  end

  // a held result only blocks the input once the machine is stopped
  assign in_stall = !(st_r == S_IDLE && !(stop_r && ov_r));
  assign out_valid = ov_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; pc_r <= '0; sp_r <= SP_RST;
      stop_r <= 1'b0; scode_r <= ER_NONE; ov_r <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(DATA_DEPTH - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (in_valid && !(stop_r && ov_r)) begin
          in_r <= in_data;
          if (stop_r) begin
            out_r <= '{next_pc: pc_r, event_res: (scode_r != ER_NONE) ? EV_ERR : EV_HALT,
                       event_value: 32'sd0, error_code: scode_r};
            ov_r <= 1'b1;
          end else st_r <= S_RDA;
        end
        S_RDA: st_r <= S_RDB;
        S_RDB: begin ta_r <= rdata_r; st_r <= S_RDC; end
        S_RDC: begin tb_r <= rdata_r; st_r <= S_EXE; end
        S_EXE: begin
          if (need_c) tc_r <= rdata_r;
          if (in_r.func == OP_MPY) tc_r <= tb_r * ta_r;
          if (is_div && ta_r != 32'd0 && can_pop) begin
            dna_r <= tb_r[31]; dnb_r <= ta_r[31];
            dq_r <= tb_r[31] ? 32'd0 - tb_r : tb_r;
            dmb_r <= ta_r[31] ? 32'd0 - ta_r : ta_r;
            drem_r <= '0; dcnt_r <= 6'd0; st_r <= S_DIV;
          end else st_r <= S_WB;
        end
        S_DIV: begin
          if (dcnt_r == 6'd32) begin
            if (in_r.func == OP_MOD) tc_r <= dna_r ? 32'd0 - drem_r : drem_r;
            else tc_r <= (dna_r != dnb_r) ? 32'd0 - dq_r : dq_r;
            st_r <= S_WB;
          end else begin
            dcnt_r <= dcnt_r + 6'd1;
            if (!dtrial[32]) begin
              drem_r <= dtrial[31:0]; dq_r <= {dq_r[30:0], 1'b1};
            end else begin
              drem_r <= {drem_r[30:0], dq_r[31]}; dq_r <= {dq_r[30:0], 1'b0};
            end
          end
        end
        S_WB: st_r <= S_OUT;
        // wait here while the previous result is still held
        S_OUT: if (!ov_r) begin
          if (fault != ER_NONE) begin
            stop_r <= 1'b1; scode_r <= fault;
            out_r <= '{next_pc: pc_r, event_res: EV_ERR, event_value: 32'sd0,
                       error_code: fault};
          end else if (halt) begin
            stop_r <= 1'b1; scode_r <= ER_NONE;
            out_r <= '{next_pc: pc_r, event_res: EV_HALT, event_value: 32'sd0,
                       error_code: ER_NONE};
          end else begin
            pc_r <= npc; sp_r <= sp_n;
            out_r <= '{next_pc: npc, event_res: ev, event_value: val,
                       error_code: ER_NONE};
          end
          ov_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_no_in_when_busy, clk, rst_n, (st_r != S_IDLE) |-> in_stall)
  `ASSERT_CLK(a_sp_range, clk, rst_n, (sp_r <= SP_FULL))
  `ASSERT_CLK(a_stop_holds, clk, rst_n, stop_r |=> stop_r)
  `ASSERT_CLK(a_wb_only_ok, clk, rst_n, (we && st_r != S_CLR) |-> (st_r == S_WB && wb_fire))

endmodule
